### rtl/half_float_converter_assert.svh
`ifndef HALF_FLOAT_CONVERTER_ASSERT_SVH
`define HALF_FLOAT_CONVERTER_ASSERT_SVH

// assert that a condition implies a consequence in the same cycle
`define HFC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// assert that a condition implies a consequence in the next cycle
`define HFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/hfc_pkg.sv
package hfc_pkg;

    typedef enum logic {
        KIND_H2F = 1'b0,
        KIND_F2H = 1'b1
    } kind_t;

    localparam logic [31:0] H2F_SUB_BASE = 32'h3880_0000;
    localparam logic [31:0] F_INF        = 32'h7F80_0000;
    localparam logic [15:0] H_INF        = 16'h7C00;
    localparam logic [10:0] H_IMPLICIT   = 11'h400;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e5;
        logic [9:0]  m;
        logic [3:0]  k;
        logic [9:0]  mn;
        logic [31:0] r;
        sgn = {h[15], 31'd0};
        e5  = h[14:10];
        m   = h[9:0];
        k   = 4'd0;
        for (int i = 9; i >= 0; i--)
        begin
            if (m[i] && k == 4'd0)
            begin
                k = 4'(10 - i);
            end
        end
        mn = 10'(m << k);
        if (e5 == 5'd0)
        begin
            if (m == 10'd0)
                r = sgn;
            else
                r = sgn | (H2F_SUB_BASE - {5'd0, k, 23'd0}) | {9'd0, mn, 13'd0};
        end
        else if (e5 == 5'd31)
            r = sgn | F_INF | {9'd0, m, 13'd0};
        else
            r = sgn | {1'b0, 8'({3'd0, e5} + 8'd112), m, 13'd0};
        return r;
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic [15:0] sgn;
        logic [7:0]  ef;
        logic [22:0] m;
        logic [4:0]  sh;
        logic [15:0] imp;
        logic [15:0] r;
        sgn = {f[31], 15'd0};
        ef  = f[30:23];
        m   = f[22:0];
        sh  = 5'(8'd126 - ef);
        imp = {5'd0, 11'(H_IMPLICIT >> (sh - 5'd13))};
        if (ef < 8'd103)
            r = sgn;
        else if (ef < 8'd113)
            r = (sgn | imp) + 16'(m >> sh);
        else if (ef <= 8'd142)
            r = (sgn | {1'b0, 5'(ef - 8'd112), 10'd0}) + {6'd0, m[22:13]};
        else if (ef != 8'd255)
            r = sgn | H_INF;
        else
            r = (sgn | H_INF) + {6'd0, m[22:13]};
        return r;
    endfunction

endpackage

### rtl/half_float_converter.sv
// channel | signals                          | handshake
// input   | kind, half_in, float_in          | start && !busy
// result  | result_bits                      | done, one cycle
// One word per cycle; each word passes through the input and result registers
// before its result appears. busy is always low. Reset clears the valid flags only.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "half_float_converter_assert.svh"

module half_float_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [15:0] half_in,
    input  logic [31:0] float_in,
    output logic        done,
    output logic [31:0] result_bits
);
    import hfc_pkg::*;

    logic        in_vld_reg;
    logic        kind_reg;
    logic [15:0] half_reg;
    logic [31:0] float_reg;
    logic        out_vld_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;

    assign busy = 1'b0;

    always_comb
    begin
        if (kind_t'(kind_reg) == KIND_H2F)
            res_next = half_to_single(half_reg);
        else
            res_next = {16'd0, single_to_half(float_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg  <= kind;
            half_reg  <= half_in;
            float_reg <= float_in;
        end
        if (in_vld_reg)
            res_reg <= res_next;
    end

    assign done        = out_vld_reg;
    assign result_bits = res_reg;

    `HFC_ASSERT_NEXT(a_start_done, start, ##1 done)
    `HFC_ASSERT_IMPL(a_f2h_upper, in_vld_reg && kind_reg, res_next[31:16] == 16'd0)
    `HFC_ASSERT_NEXT(a_done_src, in_vld_reg, done)

endmodule
